@@ sv/bbi2c_pkg.sv @@
// Shared types and constants of the bit-banged I2C write master.
package bbi2c_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT    = 1'b1;

  localparam logic [7:0]  DEV_ADDR_RST    = 8'd120;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd1000;

  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_ABORT = 2'd1;
  localparam logic [1:0] STAT_BUSY  = 2'd2;

  typedef enum logic {
    OP_REQ  = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic       func;
    logic       is_data;
    logic [7:0] payload;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] ctrl_byte;
    logic [7:0] payload;
    logic       sda_in;
  } cmd_t;

endpackage

@@ sv/bbi2c_front.sv @@
// Front end: accepts input beats, decodes them into commands and queues them.
module bbi2c_front #(
  parameter int unsigned QUEUE_DEPTH = bbi2c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bbi2c_pkg::req_t   in_data_i,
  input  logic              pop_i,
  output logic              head_valid_o,
  output bbi2c_pkg::cmd_t   head_o
);
  import bbi2c_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;
  cmd_t             cmd;

  always_comb begin
    cmd.op        = in_data_i.func ? OP_TICK : OP_REQ;
    cmd.ctrl_byte = in_data_i.is_data ? CTRL_DATA : CTRL_CMD;
    cmd.payload   = in_data_i.payload;
    cmd.sda_in    = in_data_i.sda_in;
  end

  assign in_stall_o   = (count_q == CNT_FULL);
  assign head_valid_o = (count_q != '0);
  assign head_o       = entry_q[rd_ptr_q];
  assign push         = in_valid_i && !in_stall_o;
  assign pop          = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= cmd;
    end
  end

endmodule

@@ sv/bbi2c_back.sv @@
// Back end: pin sequencer, one queued command per cycle to an output register unless stalled.
module bbi2c_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  bbi2c_pkg::cmd_t head_i,
  output logic            pop_o,
  input  logic [7:0]      dev_addr_i,
  input  logic [15:0]     ack_timeout_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bbi2c_pkg::res_t out_data_o
);
  import bbi2c_pkg::*;

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_START = 4'd1;
  localparam logic [3:0] PH_BIT   = 4'd2;
  localparam logic [3:0] PH_ACK   = 4'd3;
  localparam logic [3:0] PH_POLL  = 4'd4;
  localparam logic [3:0] PH_STOP  = 4'd5;

  logic [3:0]  phase_q, phase_d;
  logic [1:0]  step_q, step_d;
  logic [2:0]  bit_q, bit_d;
  logic [1:0]  slot_q, slot_d;
  logic        retried_q, retried_d;
  logic [15:0] poll_q, poll_d;
  logic [7:0]  payload_q, payload_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        out_valid_q;
  res_t        out_data_q, res;
  logic        active, done;
  logic [1:0]  status;
  logic [7:0]  cur_byte;

  assign pop_o       = head_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign active      = (phase_q >= PH_START) && (phase_q <= PH_STOP);

  always_comb begin
    unique case (slot_q)
      2'd0:    cur_byte = dev_addr_i;
      2'd1:    cur_byte = ctrl_q;
      default: cur_byte = payload_q;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    step_d    = step_q;
    bit_d     = bit_q;
    slot_d    = slot_q;
    retried_d = retried_q;
    poll_d    = poll_q;
    payload_d = payload_q;
    ctrl_d    = ctrl_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    done      = 1'b0;
    status    = STAT_OK;
    if (head_i.op == OP_REQ) begin
      if (active) begin
        status = STAT_BUSY;
      end else begin
        payload_d = head_i.payload;
        ctrl_d    = head_i.ctrl_byte;
        phase_d   = PH_START;
        step_d    = '0;
        bit_d     = '0;
        slot_d    = '0;
        retried_d = 1'b0;
        poll_d    = '0;
      end
    end else if (active) begin
      unique case (phase_q)
        PH_START: begin
          unique case (step_q)
            2'd0:    scl_d = 1'b1;
            2'd1:    sda_d = 1'b1;
            2'd2:    sda_d = 1'b0;
            default: scl_d = 1'b0;
          endcase
          if (step_q == 2'd3) begin
            phase_d = PH_BIT;
            step_d  = '0;
            bit_d   = '0;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        PH_BIT: begin
          priority if (step_q == 2'd0) begin
            scl_d  = 1'b0;
            step_d = 2'd1;
          end else if (step_q == 2'd1) begin
            sda_d  = cur_byte[~bit_q];
            step_d = 2'd2;
          end else begin
            scl_d  = 1'b1;
            step_d = '0;
            if (bit_q == 3'd7) begin
              bit_d   = '0;
              phase_d = PH_ACK;
            end else begin
              bit_d = bit_q + 1'b1;
            end
          end
        end
        PH_ACK: begin
          priority if (step_q == 2'd0) begin
            scl_d  = 1'b0;
            step_d = 2'd1;
          end else if (step_q == 2'd1) begin
            sda_d  = 1'b1;
            step_d = 2'd2;
          end else begin
            scl_d   = 1'b1;
            step_d  = '0;
            poll_d  = '0;
            phase_d = PH_POLL;
          end
        end
        PH_POLL: begin
          priority if (!head_i.sda_in) begin
            scl_d     = 1'b0;
            poll_d    = '0;
            retried_d = 1'b0;
            step_d    = '0;
            bit_d     = '0;
            if (slot_q >= 2'd2) begin
              phase_d = PH_STOP;
            end else begin
              slot_d  = slot_q + 1'b1;
              phase_d = PH_BIT;
            end
          end else if (poll_q >= ack_timeout_i) begin
            scl_d  = 1'b0;
            poll_d = '0;
            step_d = '0;
            bit_d  = '0;
            if (!retried_q) begin
              retried_d = 1'b1;
              phase_d   = PH_BIT;
            end else begin
              retried_d = 1'b0;
              phase_d   = PH_IDLE;
              done      = 1'b1;
              status    = STAT_ABORT;
            end
          end else begin
            poll_d = poll_q + 1'b1;
          end
        end
        PH_STOP: begin
          priority if (step_q == 2'd0) begin
            sda_d  = 1'b0;
            step_d = 2'd1;
          end else if (step_q == 2'd1) begin
            scl_d  = 1'b1;
            step_d = 2'd2;
          end else begin
            sda_d   = 1'b1;
            step_d  = '0;
            phase_d = PH_IDLE;
            done    = 1'b1;
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_out  = scl_d;
    res.sda_out  = sda_d;
    res.busy_res = (phase_d >= PH_START) && (phase_d <= PH_STOP);
    res.done_res = done;
    res.status   = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      step_q      <= '0;
      bit_q       <= '0;
      slot_q      <= '0;
      retried_q   <= 1'b0;
      poll_q      <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q   <= phase_d;
        step_q    <= step_d;
        bit_q     <= bit_d;
        slot_q    <= slot_d;
        retried_q <= retried_d;
        poll_q    <= poll_d;
        scl_q     <= scl_d;
        sda_q     <= sda_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      payload_q  <= payload_d;
      ctrl_q     <= ctrl_d;
      out_data_q <= res;
    end
  end

endmodule

@@ sv/bitbang_i2c_write_retry_top.sv @@
// Top level of the bit-banged I2C write master with one retry per byte.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): each beat is either a
// write request (func = 0) or a tick (func = 1) that advances the pin
// sequence by one step. Every accepted beat yields exactly one result beat
// on the output channel (out_valid_o / out_stall_i / out_data_o) with the
// SCL/SDA drive levels, busy and done flags and a status code.
// A beat is registered in the queue, then its result in the output register;
// throughput is one beat per cycle, set by the pin sequencer in the back end.
// A queue of QUEUE_DEPTH commands sits between front and back, so input beats
// are still taken while a result waits; in_stall_o rises when it fills.
// When out_stall_i holds the result register, the sequencer pauses and the
// queue absorbs further input until full.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes the device
// address (index 0) or the acknowledge timeout (index 1); write it only
// while the block is idle.
// Reset brings SCL and SDA released high, the sequencer idle, the queue
// empty, the address to 120 and the timeout to 1000.
module bitbang_i2c_write_retry_top #(
  parameter int unsigned QUEUE_DEPTH = bbi2c_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  bbi2c_pkg::req_t                      in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output bbi2c_pkg::res_t                      out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bbi2c_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bbi2c_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import bbi2c_pkg::*;

  logic [7:0]  dev_addr_q;
  logic [15:0] ack_timeout_q;
  logic        head_valid;
  logic        pop;
  cmd_t        head;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q    <= DEV_ADDR_RST;
      ack_timeout_q <= ACK_TIMEOUT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEVICE_ADDRESS: dev_addr_q    <= cfg_data_i[7:0];
        CFG_ACK_TIMEOUT:    ack_timeout_q <= cfg_data_i[15:0];
        default:            dev_addr_q    <= dev_addr_q;
      endcase
    end
  end

  bbi2c_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .pop_i       (pop),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  bbi2c_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .dev_addr_i   (dev_addr_q),
    .ack_timeout_i(ack_timeout_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

`ifndef SYNTHESIS
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("transfer done while still busy");

  a_refuse_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_BUSY) |->
      out_data_o.busy_res && !out_data_o.done_res)
    else $error("refused request without a transfer in progress");

  a_abort_scl_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == STAT_ABORT) |->
      out_data_o.done_res && !out_data_o.scl_out)
    else $error("abort must end the transfer with SCL low");

  a_pop_fills_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid_o)
    else $error("sequencer step lost its result beat");
`endif

endmodule
